// ===== hdl/assert_macros.svh =====
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// property checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/lap_pkg.sv =====
// shared widths, reset values and types of the laplacian edge filter
// no dependencies
package lap_pkg;

    localparam int PIX_W         = 8;
    localparam int COL_W         = 10;
    localparam int ROW_W         = 12;
    localparam int WIDTH_REG_W   = 11;
    localparam int HEIGHT_REG_W  = 13;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_IDX_W     = 2;
    localparam int CMP_W         = 14;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int MIN_DIM       = 3;
    localparam int RST_WIDTH     = 640;
    localparam int RST_HEIGHT    = 480;
    localparam int SUM_W         = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1
    } t_cfg_idx;

    // pixel in flight between the line store read and the filter
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] px;
        logic [COL_W-1:0] ccol;
        logic [ROW_W-1:0] crow;
        logic             produce;
        logic             frame_end;
    } t_tag;

endpackage

// ===== hdl/lap_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module lap_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/lap_ctrl.sv =====
// configuration registers, raster counters, line store read and stage-1 tag
// depends on lap_pkg
module lap_ctrl import lap_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_pix_valid,
    input  logic [PIX_W-1:0]             i_pixel,
    output logic                         o_pix_stall,
    input  logic                         i_s1_ready,
    output logic                         o_rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0] o_rd_addr,
    output t_tag                         o_tag,
    output logic [$clog2(MAX_WIDTH)-1:0] o_s1_col
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [WIDTH_REG_W-1:0]  r_width;
    logic [HEIGHT_REG_W-1:0] r_height;
    logic [CW-1:0]           r_col;
    logic [ROW_W-1:0]        r_row;
    t_tag                    r_s1;
    logic [CW-1:0]           r_s1_col;

    logic [CMP_W-1:0]        eff_w;
    logic [HEIGHT_REG_W-1:0] eff_h;
    logic                    last_col;
    logic                    last_row;
    logic                    accept;
    logic                    cfg_hit;
    logic [31:0]             col_m1;

    always_comb begin
        eff_w = CMP_W'(r_width);
        if (eff_w < CMP_W'(MIN_DIM)) begin
            eff_w = CMP_W'(MIN_DIM);
        end else if (eff_w > CMP_W'(MAX_WIDTH)) begin
            eff_w = CMP_W'(MAX_WIDTH);
        end
        eff_h = r_height;
        if (eff_h < HEIGHT_REG_W'(MIN_DIM)) begin
            eff_h = HEIGHT_REG_W'(MIN_DIM);
        end else if (eff_h > HEIGHT_REG_W'(MAX_HEIGHT)) begin
            eff_h = HEIGHT_REG_W'(MAX_HEIGHT);
        end
    end

    assign last_col = (CMP_W'(r_col) + CMP_W'(1)) >= eff_w;
    assign last_row = (HEIGHT_REG_W'(r_row) + HEIGHT_REG_W'(1)) >= eff_h;
    assign col_m1   = 32'(r_col) - 32'd1;

    assign accept      = i_pix_valid && (!r_s1.valid || i_s1_ready);
    assign o_pix_stall = r_s1.valid && !i_s1_ready;

    always_comb begin
        unique case (i_cfg_index)
            CFG_WIDTH, CFG_HEIGHT: cfg_hit = i_cfg_valid;
            default:               cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_REG_W'(RST_WIDTH);
            r_height <= HEIGHT_REG_W'(RST_HEIGHT);
            r_col    <= '0;
            r_row    <= '0;
        end else if (cfg_hit) begin
            if (i_cfg_index == CFG_WIDTH) begin
                r_width <= i_cfg_data[WIDTH_REG_W-1:0];
            end else begin
                r_height <= i_cfg_data;
            end
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (accept) begin
            r_s1.valid <= 1'b1;
        end else if (i_s1_ready) begin
            r_s1.valid <= 1'b0;
        end
        if (accept) begin
            r_s1.px        <= i_pixel;
            r_s1.ccol      <= col_m1[COL_W-1:0];
            r_s1.crow      <= r_row - ROW_W'(1);
            r_s1.produce   <= (r_col >= CW'(2)) && (r_row >= ROW_W'(2));
            r_s1.frame_end <= last_col && last_row;
            r_s1_col       <= r_col;
        end
    end

    assign o_rd_en   = accept;
    assign o_rd_addr = r_col;
    assign o_tag     = r_s1;
    assign o_s1_col  = r_s1_col;

endmodule

// ===== hdl/lap_win.sv =====
// 3x3 window, kernel sum with clamp, line store write-back and output register
// depends on lap_pkg
module lap_win import lap_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_tag                         i_tag,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_s1_col,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  logic [2*PIX_W-1:0]           i_ram_q,
    output logic                         o_s1_ready,
    output logic                         o_we,
    output logic [$clog2(MAX_WIDTH)-1:0] o_waddr,
    output logic [2*PIX_W-1:0]           o_wdata,
    input  logic                         i_res_stall,
    output logic                         o_res_valid,
    output logic [PIX_W-1:0]             o_edge_value,
    output logic [COL_W-1:0]             o_center_col,
    output logic [ROW_W-1:0]             o_center_row,
    output logic                         o_frame_end
);

    logic [PIX_W-1:0]   r_win [6];
    logic               r_fwd_hit;
    logic [2*PIX_W-1:0] r_fwd_data;
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_edge;
    logic [COL_W-1:0]   r_ccol;
    logic [ROW_W-1:0]   r_crow;
    logic               r_fend;

    logic               out_free;
    logic               adv;
    logic [2*PIX_W-1:0] mem;
    logic [PIX_W-1:0]   top;
    logic [PIX_W-1:0]   mid;
    logic [SUM_W-1:0]   neigh;
    logic [SUM_W-1:0]   acc;
    logic [PIX_W-1:0]   clamped;

    assign out_free   = !r_out_valid || !i_res_stall;
    assign adv        = i_tag.valid && out_free;
    assign o_s1_ready = out_free;

    // a write landing on the address being read would be missed by the ram
    assign mem = r_fwd_hit ? r_fwd_data : i_ram_q;
    assign top = mem[2*PIX_W-1:PIX_W];
    assign mid = mem[PIX_W-1:0];

    assign o_we    = adv;
    assign o_waddr = i_s1_col;
    assign o_wdata = {mid, i_tag.px};

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_hit  <= adv && (i_s1_col == i_rd_addr);
            r_fwd_data <= {mid, i_tag.px};
        end
    end

    always_comb begin
        neigh = SUM_W'(r_win[0]) + SUM_W'(r_win[1]) + SUM_W'(r_win[2]) + SUM_W'(r_win[3])
              + SUM_W'(r_win[5]) + SUM_W'(top) + SUM_W'(mid) + SUM_W'(i_tag.px);
        acc   = (SUM_W'(r_win[4]) << 3) - neigh;
        if (acc[SUM_W-1]) begin
            clamped = '0;
        end else if (acc[SUM_W-2:PIX_W] != '0) begin
            clamped = '1;
        end else begin
            clamped = acc[PIX_W-1:0];
        end
    end

    // entries 0..2 column c-2, 3..5 column c-1, top to bottom
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (adv) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top;
            r_win[4] <= mid;
            r_win[5] <= i_tag.px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= i_tag.produce;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_edge <= clamped;
            r_ccol <= i_tag.ccol;
            r_crow <= i_tag.crow;
            r_fend <= i_tag.frame_end;
        end
    end

    assign o_res_valid  = r_out_valid;
    assign o_edge_value = r_edge;
    assign o_center_col = r_ccol;
    assign o_center_row = r_crow;
    assign o_frame_end  = r_fend;

endmodule

// ===== hdl/laplacian_3x3_edge_filter.sv =====
// top level of the 3x3 laplacian edge filter
// depends on lap_pkg, lap_ram, lap_ctrl, lap_win
//
// pixel channel: i_pix_valid / o_pix_stall carry one 8-bit sample per beat in
// raster order. result channel: o_res_valid / i_res_stall carry the clamped
// response of an interior pixel with its column, row and an end-of-frame flag.
// border pixels give no result beat.
// config channel: i_cfg_valid / o_cfg_ready write image_width (index 0) or
// image_height (index 1); o_cfg_ready is always high and any write to a known
// index restarts the frame. write only while the block is idle.
// throughput is one pixel per cycle while o_pix_stall is low: each pixel does
// one read of the combined line store ram and one write-back to it when it
// leaves the stage-1 register. a pixel beat that completes a window reaches
// the result beat through the ram read and then the output register.
// when i_res_stall holds a waiting result, the filter stage takes at most one
// more pixel (none if it is full), then o_pix_stall stays high until it clears.
// reset (synchronous, active low) restores 640 x 480, clears counters, window
// and valid flags; the line store needs no clearing pass.
module laplacian_3x3_edge_filter import lap_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_pix_valid,
    output logic                  o_pix_stall,
    input  logic [PIX_W-1:0]      i_pixel,
    output logic                  o_res_valid,
    input  logic                  i_res_stall,
    output logic [PIX_W-1:0]      o_edge_value,
    output logic [COL_W-1:0]      o_center_col,
    output logic [ROW_W-1:0]      o_center_row,
    output logic                  o_frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);

    t_tag               tag;
    logic [CW-1:0]      s1_col;
    logic               s1_ready;
    logic               rd_en;
    logic [CW-1:0]      rd_addr;
    logic               we;
    logic [CW-1:0]      waddr;
    logic [2*PIX_W-1:0] wdata;
    logic [2*PIX_W-1:0] ram_q;

    assign o_cfg_ready = 1'b1;

    lap_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix_valid (i_pix_valid),
        .i_pixel     (i_pixel),
        .o_pix_stall (o_pix_stall),
        .i_s1_ready  (s1_ready),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_tag       (tag),
        .o_s1_col    (s1_col)
    );

    // upper byte: row two above, lower byte: row above
    lap_ram #(.WIDTH(2*PIX_W), .DEPTH(MAX_WIDTH)) u_lines (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    lap_win #(.MAX_WIDTH(MAX_WIDTH)) u_win (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tag        (tag),
        .i_s1_col     (s1_col),
        .i_rd_en      (rd_en),
        .i_rd_addr    (rd_addr),
        .i_ram_q      (ram_q),
        .o_s1_ready   (s1_ready),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .i_res_stall  (i_res_stall),
        .o_res_valid  (o_res_valid),
        .o_edge_value (o_edge_value),
        .o_center_col (o_center_col),
        .o_center_row (o_center_row),
        .o_frame_end  (o_frame_end)
    );

endmodule

// ===== hdl/lap_chk.sv =====
// port-level checks of the laplacian edge filter, bound to the top level
// depends on lap_pkg and assert_macros.svh
`include "assert_macros.svh"

module lap_chk import lap_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  i_pix_valid,
    input logic                  o_pix_stall,
    input logic [PIX_W-1:0]      i_pixel,
    input logic                  o_res_valid,
    input logic                  i_res_stall,
    input logic [PIX_W-1:0]      o_edge_value,
    input logic [COL_W-1:0]      o_center_col,
    input logic [ROW_W-1:0]      o_center_row,
    input logic                  o_frame_end
);

    `ASSERT_RST(a_res_hold, i_clk, i_rst_n, o_res_valid && i_res_stall |=> o_res_valid && $stable(o_edge_value) && $stable(o_center_col) && $stable(o_center_row) && $stable(o_frame_end), "result changed while stalled")
    `ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !o_res_valid, "result valid right after reset")
    `ASSERT_RST(a_interior, i_clk, i_rst_n, o_res_valid |-> (o_center_col != '0) && (o_center_row != '0), "result for a border pixel")
    `ASSERT_RST(a_stall_src, i_clk, i_rst_n, o_pix_stall |-> o_res_valid && i_res_stall, "input stalled without a held result")

endmodule

bind laplacian_3x3_edge_filter lap_chk u_chk (.*);

// ===== tb/laplacian_3x3_edge_filter_tb.sv =====
`timescale 1ns / 1ps
// testbench of the 3x3 laplacian edge filter: streams directed and random images
// with register changes in between and checks every result beat in order
// depends on lap_pkg and laplacian_3x3_edge_filter
module laplacian_3x3_edge_filter_tb;
    import lap_pkg::*;

    localparam int STORE_DEPTH   = DEF_MAX_WIDTH;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_PIXELS = 1280;
    localparam int MAX_WAIT      = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [PIX_W-1:0]      px;
        int                    gap;
        bit                    hurry;
    } t_feed_item;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             frame_end;
    } t_edge_res;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_pix_valid = 1'b0;
    logic [PIX_W-1:0]      i_pixel     = '0;
    logic                  i_res_stall = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_pix_stall;
    logic                  o_res_valid;
    logic [PIX_W-1:0]      o_edge_value;
    logic [COL_W-1:0]      o_center_col;
    logic [ROW_W-1:0]      o_center_row;
    logic                  o_frame_end;

    t_feed_item feed_q[$];
    t_edge_res  edge_q[$];

    // filter state as the block should hold it
    logic [PIX_W-1:0]        row_above  [STORE_DEPTH];
    logic [PIX_W-1:0]        row_above2 [STORE_DEPTH];
    logic [PIX_W-1:0]        win [6];
    int unsigned             col_pos = 0;
    int unsigned             row_pos = 0;
    logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_REG_W'(RST_WIDTH);
    logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_REG_W'(RST_HEIGHT);

    int gap_cnt   = 0;
    int quiet_cnt = 0;
    int stall_cnt = 0;
    bit hurry_now = 1'b0;
    int pix_sent   = 0;
    int cfg_writes = 0;
    int res_seen   = 0;
    int frames_seen = 0;
    int fail_cnt   = 0;

    laplacian_3x3_edge_filter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_pix_valid  (i_pix_valid),
        .o_pix_stall  (o_pix_stall),
        .i_pixel      (i_pixel),
        .o_res_valid  (o_res_valid),
        .i_res_stall  (i_res_stall),
        .o_edge_value (o_edge_value),
        .o_center_col (o_center_col),
        .o_center_row (o_center_row),
        .o_frame_end  (o_frame_end)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned sat_dim(int unsigned v, int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx,
                                      logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_WIDTH) begin
            width_reg = data[WIDTH_REG_W-1:0];
        end else if (idx == CFG_HEIGHT) begin
            height_reg = data[HEIGHT_REG_W-1:0];
        end else begin
            return;
        end
        col_pos = 0;
        row_pos = 0;
    endfunction

    // one pixel through the window; queues the response when the centre is interior
    function automatic void predict_pixel(logic [PIX_W-1:0] px);
        int unsigned w, h;
        logic [PIX_W-1:0] top, mid;
        int acc;
        t_edge_res res;
        w = sat_dim(width_reg, STORE_DEPTH);
        h = sat_dim(height_reg, MAX_HEIGHT);
        top = row_above2[col_pos];
        mid = row_above[col_pos];
        if (col_pos >= 2 && row_pos >= 2) begin
            acc = 8 * int'(win[4]) - int'(win[0]) - int'(win[1]) - int'(win[2])
                - int'(win[3]) - int'(win[5]) - int'(top) - int'(mid) - int'(px);
            if (acc < 0) begin
                res.value = '0;
            end else if (acc > 255) begin
                res.value = '1;
            end else begin
                res.value = PIX_W'(acc);
            end
            res.col = COL_W'(col_pos - 1);
            res.row = ROW_W'(row_pos - 1);
            res.frame_end = (row_pos + 1 >= h) && (col_pos + 1 >= w);
            edge_q.push_back(res);
        end
        row_above2[col_pos] = mid;
        row_above[col_pos]  = px;
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top;
        win[4] = mid;
        win[5] = px;
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_feed_item it;
        it.is_cfg = 1'b1;
        it.idx    = idx;
        it.data   = data;
        it.px     = '0;
        it.gap    = 0;
        it.hurry  = 1'b0;
        feed_q.push_back(it);
    endfunction

    function automatic void add_pix(logic [PIX_W-1:0] px, bit hurry);
        t_feed_item it;
        it.is_cfg = 1'b0;
        it.idx    = CFG_WIDTH;
        it.data   = '0;
        it.px     = px;
        it.gap    = hurry ? 0 : $urandom_range(0, MAX_WAIT);
        it.hurry  = hurry;
        feed_q.push_back(it);
    endfunction

    // pixel source: 0 noise, 1 black/white, 2 smooth around a base level
    function automatic logic [PIX_W-1:0] pick_pixel(int unsigned mode, int base);
        int v;
        case (mode)
            0: return PIX_W'($urandom_range(0, 255));
            1: return $urandom_range(0, 1) ? '1 : '0;
            default: begin
                v = base + int'($urandom_range(0, 24)) - 12;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return PIX_W'(v);
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : pixel_driver
        logic pix_busy, cfg_busy;
        int gap_next, quiet_next;
        t_feed_item nxt;
        if (!i_rst_n) begin
            i_pix_valid <= 1'b0;
            i_cfg_valid <= 1'b0;
            gap_cnt     <= 0;
            quiet_cnt   <= 0;
        end else begin
            pix_busy   = i_pix_valid;
            cfg_busy   = i_cfg_valid;
            gap_next   = gap_cnt;
            quiet_next = (quiet_cnt < SETTLE_CYCLES) ? quiet_cnt + 1 : quiet_cnt;
            if (i_pix_valid && !o_pix_stall) begin
                predict_pixel(i_pixel);
                pix_sent++;
                pix_busy   = 1'b0;
                quiet_next = 0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_cfg(i_cfg_index, i_cfg_data);
                cfg_writes++;
                cfg_busy = 1'b0;
            end
            if (!pix_busy && !cfg_busy && feed_q.size() != 0) begin
                nxt = feed_q[0];
                if (nxt.is_cfg) begin
                    // register writes only once the pipeline has drained
                    if (!o_res_valid && edge_q.size() == 0 && quiet_next >= SETTLE_CYCLES) begin
                        i_cfg_index <= nxt.idx;
                        i_cfg_data  <= nxt.data;
                        cfg_busy = 1'b1;
                        void'(feed_q.pop_front());
                    end
                end else if (gap_next < nxt.gap) begin
                    gap_next++;
                end else begin
                    i_pixel   <= nxt.px;
                    hurry_now <= nxt.hurry;
                    pix_busy = 1'b1;
                    gap_next = 0;
                    void'(feed_q.pop_front());
                end
            end
            i_pix_valid <= pix_busy;
            i_cfg_valid <= cfg_busy;
            gap_cnt     <= gap_next;
            quiet_cnt   <= quiet_next;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_edge_res got, want;
        int stall_next;
        if (!i_rst_n) begin
            i_res_stall <= 1'b0;
            stall_cnt   <= 0;
        end else begin
            stall_next = (stall_cnt > 0) ? stall_cnt - 1 : 0;
            if (o_res_valid && !i_res_stall) begin
                got = {o_edge_value, o_center_col, o_center_row, o_frame_end};
                res_seen++;
                if (o_frame_end) frames_seen++;
                if (edge_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: expected no result beat, got value=%0d col=%0d row=%0d end=%0b",
                             $time, got.value, got.col, got.row, got.frame_end);
                end else begin
                    want = edge_q.pop_front();
                    if (got.value !== want.value || got.col !== want.col ||
                        got.row !== want.row || got.frame_end !== want.frame_end) begin
                        fail_cnt++;
                        $display("%0t: expected value=%0d col=%0d row=%0d end=%0b,",
                                 $time, want.value, want.col, want.row, want.frame_end);
                        $display("    got value=%0d col=%0d row=%0d end=%0b",
                                 got.value, got.col, got.row, got.frame_end);
                    end
                end
                stall_next = hurry_now ? 0 : $urandom_range(0, MAX_WAIT);
            end
            stall_cnt   <= stall_next;
            i_res_stall <= (stall_next > 0);
        end
    end

    initial begin : stimulus
        int unsigned mode, n, sel, rand_pix;
        int base;
        bit hurry;
        logic [CFG_DATA_W-1:0] data;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            row_above[i]  = '0;
            row_above2[i] = '0;
        end
        for (int i = 0; i < 6; i++) win[i] = '0;

        // widths and heights below the minimum act as 3x3: lone bright centre, then lone dark one
        add_cfg(CFG_WIDTH, CFG_DATA_W'(0));
        add_cfg(CFG_HEIGHT, CFG_DATA_W'(2));
        for (int i = 0; i < 9; i++) add_pix((i == 4) ? '1 : '0, 1'b0);
        for (int i = 0; i < 9; i++) begin
            // a write to an unused index mid-frame must not restart the frame
            if (i == 4) add_cfg(CFG_SPARE_HI, '1);
            add_pix((i == 4) ? '0 : '1, 1'b0);
        end

        rand_pix = 0;
        while (rand_pix < RANDOM_PIXELS) begin
            if ($urandom_range(0, 3) != 0) begin
                sel = $urandom_range(0, 7);
                if (sel == 0) data = CFG_DATA_W'($urandom_range(0, MIN_DIM - 1));
                else if (sel == 1) data = CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
                else data = CFG_DATA_W'($urandom_range(MIN_DIM, 12));
                add_cfg(CFG_WIDTH, data);
            end
            if ($urandom_range(0, 3) != 0) begin
                sel = $urandom_range(0, 7);
                if (sel == 0) data = CFG_DATA_W'($urandom_range(0, MIN_DIM - 1));
                else if (sel == 1) data = CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
                else data = CFG_DATA_W'($urandom_range(MIN_DIM, 8));
                add_cfg(CFG_HEIGHT, data);
            end
            if ($urandom_range(0, 7) == 0)
                add_cfg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                        CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
            mode  = $urandom_range(0, 2);
            base  = $urandom_range(0, 255);
            hurry = ($urandom_range(0, 3) == 0);
            n     = $urandom_range(10, 150);
            for (int i = 0; i < n; i++) add_pix(pick_pixel(mode, base), hurry);
            rand_pix += n;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk); while (feed_q.size() != 0 || i_pix_valid || i_cfg_valid);
        while (edge_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Fed %0d pixels across %0d register writes; checked %0d edge results,",
                 pix_sent, cfg_writes, res_seen);
        $display("%0d of them closing a frame, %0d failures.", frames_seen, fail_cnt);
        if (fail_cnt == 0 && edge_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("Run timed out with %0d results still expected.", edge_q.size());
        $display("Verification failed");
        $finish;
    end

endmodule
